@@ hdl/prbd_pkg.sv @@
// Package for the priority ring buffer with drop: sizes, result codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package prbd_pkg;

    // Ring geometry
    localparam int SLOTS       = 8;
    localparam int PTR_W       = $clog2(SLOTS);
    localparam int OCC_W       = $clog2(SLOTS + 1);
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = (OCC_W > 4) ? OCC_W : 4;

    // Field widths
    localparam int SRC_W  = 4;
    localparam int TAG_W  = 16;
    localparam int REQ_W  = 4;
    localparam int KIND_W = 2;
    localparam int OCCO_W = 4;

    // Operation codes
    localparam logic OP_STORE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_STORED     = 2'd0,
        KIND_EVICTED    = 2'd1,
        KIND_DISPATCHED = 2'd2,
        KIND_NONE       = 2'd3
    } kind_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STORE_FIND,
        ST_REQ_CHECK,
        ST_DQ_SCAN,
        ST_DQ_SEEK,
        ST_DQ_POP,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture input item
        logic ptr_adv;   // advance pointer one slot
        logic store;     // write package at pointer, evict if full
        logic none;      // nothing to dispatch
        logic scan;      // one step of the minimum search
        logic seek;      // move pointer to the best slot
        logic pop;       // dispatch and free slot at pointer
        logic emit;      // load output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic op_request;
        logic ptr_valid;
        logic full;
        logic take_zero;
        logic scan_last;
        logic res_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

@@ hdl/prbd_ctrl.sv @@
// Controller state machine for the priority ring buffer with drop.
// Depends on prbd_pkg (state_t, cmd_t, status_t).
`default_nettype none

module prbd_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire prbd_pkg::status_t status,
    output prbd_pkg::cmd_t        cmd
);
    import prbd_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_STORE_FIND;
                end
            end
            ST_STORE_FIND: begin
                if (status.op_request) begin
                    state_next = ST_REQ_CHECK;
                end else if (status.full || !status.ptr_valid) begin
                    cmd.store  = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    cmd.ptr_adv = 1'b1;
                end
            end
            ST_REQ_CHECK: begin
                if (status.take_zero) begin
                    cmd.none   = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_DQ_SCAN;
                end
            end
            ST_DQ_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DQ_SEEK;
                end
            end
            ST_DQ_SEEK: begin
                cmd.seek   = 1'b1;
                state_next = ST_DQ_POP;
            end
            ST_DQ_POP: begin
                cmd.pop    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = status.res_last ? ST_IDLE : ST_DQ_SCAN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/prbd_datapath.sv @@
// Datapath for the priority ring buffer with drop: slot registers, ring pointer,
// occupancy count, minimum search registers and the output register.
// Depends on prbd_pkg (sizes, kind_t, cmd_t, status_t).
`default_nettype none

module prbd_datapath (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire prbd_pkg::cmd_t             cmd,
    output prbd_pkg::status_t               status,
    input  wire logic                       s_operation,
    input  wire logic [prbd_pkg::SRC_W-1:0] s_source_number,
    input  wire logic [prbd_pkg::TAG_W-1:0] s_package_tag,
    input  wire logic [prbd_pkg::REQ_W-1:0] s_request_count,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [prbd_pkg::KIND_W-1:0]     m_result_kind,
    output logic [prbd_pkg::SRC_W-1:0]      m_out_source,
    output logic [prbd_pkg::TAG_W-1:0]      m_out_tag,
    output logic [prbd_pkg::OCCO_W-1:0]     m_occupied,
    output logic                            m_last
);
    import prbd_pkg::*;

    // Slot storage
    logic             slot_valid_reg  [SLOTS];
    logic [SRC_W-1:0] slot_source_reg [SLOTS];
    logic [TAG_W-1:0] slot_tag_reg    [SLOTS];

    logic [PTR_W-1:0] ptr_reg;
    logic [OCC_W-1:0] occ_reg;

    // Captured input item
    logic             op_reg;
    logic [SRC_W-1:0] src_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [REQ_W-1:0] take_reg;

    // Minimum search
    logic [PTR_W-1:0] scan_cnt_reg;
    logic [SRC_W:0]   best_reg;
    logic [PTR_W-1:0] best_pos_reg;

    // Pending result
    kind_t            res_kind_reg;
    logic [SRC_W-1:0] res_src_reg;
    logic [TAG_W-1:0] res_tag_reg;
    logic             res_last_reg;

    logic             full;
    logic [PTR_W-1:0] ptr_inc;
    logic             cur_valid;
    logic [SRC_W-1:0] cur_src;
    logic [TAG_W-1:0] cur_tag;
    logic [SRC_W:0]   best_eff;
    logic             better;
    logic [CNT_W-1:0] occ_cap;
    logic [CNT_W-1:0] req_ext;
    logic [CNT_W-1:0] take_calc;

    // Slot at the pointer
    assign cur_valid = slot_valid_reg[ptr_reg];
    assign cur_src   = slot_source_reg[ptr_reg];
    assign cur_tag   = slot_tag_reg[ptr_reg];
    assign full      = (occ_reg == OCC_W'(SLOTS));
    assign ptr_inc   = (ptr_reg == PTR_W'(SLOTS - 1)) ? '0 : ptr_reg + 1'b1;

    // Search compare: the first step sees an empty best
    assign best_eff = (scan_cnt_reg == '0) ? (SRC_W + 1)'(1 << SRC_W) : best_reg;
    assign better   = cur_valid && ({1'b0, cur_src} < best_eff);

    // Count to dispatch, capped by occupancy and the result limit
    assign occ_cap   = (CNT_W'(occ_reg) > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS)
                                                               : CNT_W'(occ_reg);
    assign req_ext   = CNT_W'(s_request_count);
    assign take_calc = (req_ext < occ_cap) ? req_ext : occ_cap;

    // Status
    always_comb begin
        status            = '0;
        status.op_request = (op_reg == OP_REQUEST);
        status.ptr_valid  = cur_valid;
        status.full       = full;
        status.take_zero  = (take_reg == '0);
        status.scan_last  = (scan_cnt_reg == PTR_W'(SLOTS - 1));
        status.res_last   = res_last_reg;
        status.out_free   = !m_valid || m_ready;
    end

    // Input capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_operation;
            src_reg <= s_source_number;
            tag_reg <= s_package_tag;
        end
    end

    // Valid bits, pointer, occupancy, dispatch count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_valid_reg[i] <= 1'b0;
            end
            ptr_reg      <= '0;
            occ_reg      <= '0;
            take_reg     <= '0;
            scan_cnt_reg <= '0;
        end else begin
            if (cmd.load) begin
                take_reg <= REQ_W'(take_calc);
            end
            if (cmd.ptr_adv) begin
                ptr_reg <= ptr_inc;
            end
            if (cmd.store) begin
                slot_valid_reg[ptr_reg] <= 1'b1;
                ptr_reg                 <= ptr_inc;
                if (!full) begin
                    occ_reg <= occ_reg + 1'b1;
                end
            end
            // Pointer walks the whole ring and comes back to its origin
            if (cmd.scan) begin
                ptr_reg      <= ptr_inc;
                scan_cnt_reg <= status.scan_last ? '0 : scan_cnt_reg + 1'b1;
            end
            if (cmd.seek) begin
                ptr_reg <= best_pos_reg;
            end
            if (cmd.pop) begin
                slot_valid_reg[ptr_reg] <= 1'b0;
                occ_reg                 <= occ_reg - 1'b1;
                take_reg                <= take_reg - 1'b1;
            end
        end
    end

    // Slot payload
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            slot_source_reg[ptr_reg] <= src_reg;
            slot_tag_reg[ptr_reg]    <= tag_reg;
        end
    end

    // Minimum search; strict compare keeps the first match from the origin
    always_ff @(posedge aclk) begin
        if (cmd.scan) begin
            if (better) begin
                best_reg     <= {1'b0, cur_src};
                best_pos_reg <= ptr_reg;
            end else begin
                best_reg <= best_eff;
            end
        end
    end

    // Pending result
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            res_kind_reg <= full ? KIND_EVICTED : KIND_STORED;
            res_src_reg  <= full ? cur_src : '0;
            res_tag_reg  <= full ? cur_tag : '0;
            res_last_reg <= 1'b1;
        end
        if (cmd.none) begin
            res_kind_reg <= KIND_NONE;
            res_src_reg  <= '0;
            res_tag_reg  <= '0;
            res_last_reg <= 1'b1;
        end
        if (cmd.pop) begin
            res_kind_reg <= KIND_DISPATCHED;
            res_src_reg  <= cur_src;
            res_tag_reg  <= cur_tag;
            res_last_reg <= (take_reg == REQ_W'(1));
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.emit) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_result_kind <= res_kind_reg;
            m_out_source  <= res_src_reg;
            m_out_tag     <= res_tag_reg;
            m_occupied    <= OCCO_W'(occ_reg);
            m_last        <= res_last_reg;
        end
    end

endmodule

`default_nettype wire

@@ hdl/priority_ring_buffer_with_drop_core.sv @@
// Priority ring buffer with drop, top level: controller plus datapath, one item at a time.
// Store: the item is captured, then the pointer walks occupied slots to a free one, or the
// item is stored at the pointer when the ring is full, then the result is emitted.
// Request: a zero count gives a "nothing available" result; otherwise each dispatch takes a
// ring walk, seek, pop and emit. Output stalls hold the result in the emit state.
// Reset (aresetn, synchronous): all slots empty, pointer at slot 0, output register empty.
`default_nettype none

module priority_ring_buffer_with_drop_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_operation,
    input  wire logic [prbd_pkg::SRC_W-1:0]  s_source_number,
    input  wire logic [prbd_pkg::TAG_W-1:0]  s_package_tag,
    input  wire logic [prbd_pkg::REQ_W-1:0]  s_request_count,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [prbd_pkg::KIND_W-1:0]      m_result_kind,
    output logic [prbd_pkg::SRC_W-1:0]       m_out_source,
    output logic [prbd_pkg::TAG_W-1:0]       m_out_tag,
    output logic [prbd_pkg::OCCO_W-1:0]      m_occupied,
    output logic                             m_last
);
    import prbd_pkg::*;

    cmd_t    cmd;
    status_t status;

    prbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    prbd_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_operation     (s_operation),
        .s_source_number (s_source_number),
        .s_package_tag   (s_package_tag),
        .s_request_count (s_request_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_out_source    (m_out_source),
        .m_out_tag       (m_out_tag),
        .m_occupied      (m_occupied),
        .m_last          (m_last)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking bench for priority_ring_buffer_with_drop_core: queue-fed driver,
// clocked result monitor and an inline ring-buffer predictor.
// Depends on prbd_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
    import prbd_pkg::*;

    typedef struct {
        logic              op;
        logic [SRC_W-1:0]  src;
        logic [TAG_W-1:0]  tag;
        logic [REQ_W-1:0]  req;
    } pkg_cmd_t;

    typedef struct {
        kind_t             kind;
        logic [SRC_W-1:0]  src;
        logic [TAG_W-1:0]  tag;
        logic [OCCO_W-1:0] occ;
        logic              last;
    } outcome_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              s_valid         = 1'b0;
    wire               s_ready;
    logic              s_operation     = OP_STORE;
    logic [SRC_W-1:0]  s_source_number = '0;
    logic [TAG_W-1:0]  s_package_tag   = '0;
    logic [REQ_W-1:0]  s_request_count = '0;
    wire               m_valid;
    logic              m_ready         = 1'b0;
    wire [KIND_W-1:0]  m_result_kind;
    wire [SRC_W-1:0]   m_out_source;
    wire [TAG_W-1:0]   m_out_tag;
    wire [OCCO_W-1:0]  m_occupied;
    wire               m_last;

    priority_ring_buffer_with_drop_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_source_number (s_source_number),
        .s_package_tag   (s_package_tag),
        .s_request_count (s_request_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_out_source    (m_out_source),
        .m_out_tag       (m_out_tag),
        .m_occupied      (m_occupied),
        .m_last          (m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    pkg_cmd_t pending_cmds[$];
    outcome_t pending_outcomes[$];
    int       items_in   = 0;
    int       mismatches = 0;
    int       hold_left  = 0;
    bit       hold_done  = 1'b0;
    wire      calm = (items_in >= 200) && (items_in < 280);

    // Mirror of the ring: slots, pointer
    bit               ring_valid [SLOTS];
    logic [SRC_W-1:0] ring_src   [SLOTS];
    logic [TAG_W-1:0] ring_tag   [SLOTS];
    int               ring_ptr;

    initial begin
        for (int i = 0; i < SLOTS; i++) ring_valid[i] = 1'b0;
        ring_ptr = 0;
    end

    function automatic int ring_count();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) if (ring_valid[i]) n++;
        return n;
    endfunction

    // Apply one accepted command to the mirror and queue the results it causes
    task automatic ring_apply(input pkg_cmd_t c);
        int       origin;
        int       occ;
        int       take;
        int       best;
        outcome_t r;
        r.src  = '0;
        r.tag  = '0;
        r.last = 1'b1;
        if (c.op == OP_STORE) begin
            r.kind = KIND_STORED;
            origin = ring_ptr;
            // walk to the first free slot, at most once around
            if (ring_valid[ring_ptr]) begin
                ring_ptr = (ring_ptr + 1) % SLOTS;
                while (ring_ptr != origin && ring_valid[ring_ptr])
                    ring_ptr = (ring_ptr + 1) % SLOTS;
            end
            if (ring_valid[ring_ptr]) begin
                r.kind = KIND_EVICTED;
                r.src  = ring_src[ring_ptr];
                r.tag  = ring_tag[ring_ptr];
            end
            ring_valid[ring_ptr] = 1'b1;
            ring_src[ring_ptr]   = c.src;
            ring_tag[ring_ptr]   = c.tag;
            ring_ptr = (ring_ptr + 1) % SLOTS;
            r.occ = OCCO_W'(ring_count());
            pending_outcomes.insert(pending_outcomes.size(), r);
        end else begin
            occ  = ring_count();
            take = c.req;
            if (take > occ) take = occ;
            if (take > MAX_RESULTS) take = MAX_RESULTS;
            if (take == 0) begin
                r.kind = KIND_NONE;
                r.occ  = OCCO_W'(occ);
                pending_outcomes.insert(pending_outcomes.size(), r);
            end else begin
                for (int k = 0; k < take; k++) begin
                    best = 16;
                    for (int i = 0; i < SLOTS; i++)
                        if (ring_valid[i] && ring_src[i] < best) best = ring_src[i];
                    // first slot with the best source from the pointer on
                    for (int s = 0; s < SLOTS; s++) begin
                        if (ring_valid[ring_ptr] && ring_src[ring_ptr] == best) break;
                        ring_ptr = (ring_ptr + 1) % SLOTS;
                    end
                    r.kind = KIND_DISPATCHED;
                    r.src  = ring_src[ring_ptr];
                    r.tag  = ring_tag[ring_ptr];
                    ring_valid[ring_ptr] = 1'b0;
                    occ--;
                    r.occ  = OCCO_W'(occ);
                    r.last = (k + 1 == take);
                    pending_outcomes.insert(pending_outcomes.size(), r);
                end
            end
        end
    endtask

    // Driver: one transfer per handshake, random gaps
    always @(posedge aclk) begin
        pkg_cmd_t c;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                c.op  = s_operation;
                c.src = s_source_number;
                c.tag = s_package_tag;
                c.req = s_request_count;
                ring_apply(c);
                items_in <= items_in + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() > 0 && (calm || $urandom_range(0, 99) >= 24)) begin
                    c = pending_cmds.pop_front();
                    s_operation     <= c.op;
                    s_source_number <= c.src;
                    s_package_tag   <= c.tag;
                    s_request_count <= c.req;
                    s_valid         <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off once traffic is flowing, so the input backs up
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && items_in >= 60) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: check each result transfer against the oldest expectation
    always @(posedge aclk) begin
        outcome_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result transfer with no expectation: kind %0d src %0d tag %h",
                           m_result_kind, m_out_source, m_out_tag);
                    mismatches++;
                end else begin
                    e = pending_outcomes.pop_front();
                    if (m_result_kind !== e.kind) begin
                        $error("result_kind: expected %0d, got %0d", e.kind, m_result_kind);
                        mismatches++;
                    end
                    if (m_out_source !== e.src) begin
                        $error("out_source: expected %0d, got %0d", e.src, m_out_source);
                        mismatches++;
                    end
                    if (m_out_tag !== e.tag) begin
                        $error("out_tag: expected %h, got %h", e.tag, m_out_tag);
                        mismatches++;
                    end
                    if (m_occupied !== e.occ) begin
                        $error("occupied: expected %0d, got %0d", e.occ, m_occupied);
                        mismatches++;
                    end
                    if (m_last !== e.last) begin
                        $error("last: expected %0d, got %0d", e.last, m_last);
                        mismatches++;
                    end
                end
            end
            m_ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 24);
        end
    end

    task automatic add_cmd(input logic op, input int src, input int tag, input int req);
        pkg_cmd_t c;
        c.op  = op;
        c.src = SRC_W'(src);
        c.tag = TAG_W'(tag);
        c.req = REQ_W'(req);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // Stimulus, reset and end of run
    initial begin
        int store_pct;
        // empty buffer: request with a count and request of zero
        add_cmd(OP_REQUEST, 15, 16'hFFFF, 3);
        add_cmd(OP_REQUEST, 0, 16'h0000, 0);
        // fill all slots, with ties on sources 0, 3 and 15
        add_cmd(OP_STORE, 15, 16'h0000, 8);
        add_cmd(OP_STORE, 3, 16'hFFFF, 0);
        add_cmd(OP_STORE, 0, 16'hA5A5, 15);
        add_cmd(OP_STORE, 7, 16'h5A5A, 0);
        add_cmd(OP_STORE, 3, 16'h1111, 0);
        add_cmd(OP_STORE, 15, 16'hFFFF, 0);
        add_cmd(OP_STORE, 0, 16'h2222, 0);
        add_cmd(OP_STORE, 9, 16'h3333, 0);
        // full ring: store evicts, zero request returns nothing
        add_cmd(OP_STORE, 1, 16'h1234, 0);
        add_cmd(OP_REQUEST, 0, 16'h0000, 0);
        add_cmd(OP_REQUEST, 0, 16'h0000, 2);
        add_cmd(OP_STORE, 0, 16'hBEEF, 0);
        add_cmd(OP_REQUEST, 0, 16'h0000, 8);
        add_cmd(OP_REQUEST, 0, 16'h0000, 5);
        // request above occupancy
        add_cmd(OP_STORE, 5, 16'h0F0F, 0);
        add_cmd(OP_STORE, 2, 16'hF0F0, 0);
        add_cmd(OP_REQUEST, 0, 16'h0000, 8);
        add_cmd(OP_STORE, 15, 16'hFFFF, 0);
        add_cmd(OP_REQUEST, 9, 16'h0000, 1);

        // random part in chunks that lean toward filling or draining
        store_pct = 60;
        for (int i = 0; i < 390; i++) begin
            if (i % 20 == 0) store_pct = ($urandom_range(0, 1) != 0) ? 85 : 45;
            add_cmd(($urandom_range(0, 99) < store_pct) ? OP_STORE : OP_REQUEST,
                    ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15),
                    $urandom_range(0, 16'hFFFF),
                    ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2) : $urandom_range(0, 8));
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() > 0 || s_valid) @(negedge aclk);
        while (pending_outcomes.size() > 0) @(negedge aclk);
        repeat (4 * (SLOTS + 3)) @(posedge aclk);

        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
